// ===== rtl/two_channel_tone_sequencer_defines.svh =====
// Assertion macros for the two-channel tone sequencer checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef TWO_CHANNEL_TONE_SEQUENCER_DEFINES_SVH
`define TWO_CHANNEL_TONE_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tone sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tone sequencer check failed");

`endif

// ===== rtl/tcts_pkg.sv =====
// Shared types, command codes and channel update functions for the tone sequencer.
// No dependencies; used by the top level and the result buffer.
package tcts_pkg;

    localparam int NOTE_DEPTH_DEF = 256;
    localparam int MOD_W          = 13;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    typedef struct packed {
        logic [7:0]  clip_start;
        logic [7:0]  pos;
        logic [15:0] wait_cnt;
        logic        active;
        logic        rep;
        logic        notify;
        logic [15:0] freq;
        logic        tone_on;
    } t_chan;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        channel;
        logic [7:0]  addr;
        logic [15:0] freq;
        logic [15:0] dur;
        logic        loop_en;
        logic        notify;
    } t_item;

    typedef struct packed {
        t_chan ch;
        logic  done;
    } t_step;

    typedef struct packed {
        logic [15:0] freq;
        logic        tone_on;
        logic        playing;
        logic        done;
        logic [7:0]  clip_start;
    } t_view;

    typedef struct packed {
        t_view music;
        t_view sfx;
    } t_result;

    // Fold an 8-bit note address into the store depth; four restoring steps
    // cover every depth from 16 upwards.
    function automatic logic [MOD_W-1:0] mod_addr(logic [7:0] a, int depth);
        logic [MOD_W-1:0] r;
        logic [MOD_W-1:0] d;
        r = {{(MOD_W-8){1'b0}}, a};
        d = '0;
        if (depth < 256) begin
            for (int k = 3; k >= 0; k--) begin
                d = MOD_W'(depth) << k;
                if (r >= d) begin
                    r = r - d;
                end
            end
        end
        return r;
    endfunction

    // One request applied to one channel; word is the note read at its position.
    function automatic t_step chan_step(t_chan ch, t_item it, logic c, logic [31:0] word);
        t_step       s;
        logic [15:0] w;
        logic [15:0] f;
        logic [15:0] d;
        s.ch   = ch;
        s.done = 1'b0;
        w      = ch.wait_cnt;
        f      = word[15:0];
        d      = word[31:16];
        unique case (it.cmd)
            CMD_TICK: begin
                if (ch.active) begin
                    if (w != 16'd0) begin
                        w = w - 16'd1;
                    end
                    s.ch.wait_cnt = w;
                    if (w == 16'd0) begin
                        if (f == 16'd0 && d == 16'd0) begin
                            if (ch.rep) begin
                                s.ch.pos      = ch.clip_start;
                                s.ch.wait_cnt = 16'd0;
                            end else begin
                                s.done = ch.notify;
                                s.ch   = '0;
                            end
                        end else begin
                            s.ch.tone_on  = (f != 16'd0);
                            s.ch.freq     = f;
                            s.ch.wait_cnt = (d == 16'd0) ? 16'd1 : d;
                            s.ch.pos      = ch.pos + 8'd1;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                s.ch = ch;
            end
            CMD_START: begin
                if (it.channel == c) begin
                    s.ch.clip_start = it.addr;
                    s.ch.pos        = it.addr;
                    s.ch.wait_cnt   = 16'd0;
                    s.ch.active     = 1'b1;
                    s.ch.rep        = it.loop_en;
                    s.ch.notify     = it.notify;
                end
            end
            CMD_STOP: begin
                if (it.channel == c) begin
                    s.done = ch.notify;
                    s.ch   = '0;
                end
            end
        endcase
        return s;
    endfunction

    function automatic t_view chan_view(t_chan ch, logic done);
        t_view v;
        v.freq       = ch.tone_on ? ch.freq : 16'd0;
        v.tone_on    = ch.tone_on;
        v.playing    = ch.active;
        v.done       = done;
        v.clip_start = ch.active ? ch.clip_start : 8'd0;
        return v;
    endfunction

endpackage

// ===== rtl/two_channel_tone_sequencer.sv =====
// Two-channel tone sequencer: note store, two-stage channel pipeline, result buffer.
// Depends on tcts_pkg, tcts_ram and tcts_obuf.
//
// Usage: one input channel (i_in_valid / o_in_ready) carries requests: a
// millisecond tick, a note write, or a start or stop for the music or effects
// channel. Every request yields exactly one result on the output channel
// (o_out_valid / i_out_ready) showing both channels after that request.
// Pipeline: an accepted request is registered into stage 1, then stage 2,
// and its result is written into the result buffer. A new request is not
// taken while the previous one is in stage 1, due to the single read port
// of the note memory, which serves the music note read in the accept cycle
// and the effects note read in the next; a note write goes through the
// write port in stage 1. Channel 0 is updated in the first stage, channel 1
// in the second, so a new request overlaps the previous one's last stage.
// Reset: both channels stopped and silent; note memory contents are
// undefined until written and need no clearing.
// Output stall: results wait in a two-entry buffer; the input is held off
// whenever the buffer could not take the results already in flight.
module two_channel_tone_sequencer #(
    parameter int NOTE_DEPTH = tcts_pkg::NOTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic        i_channel,
    input  logic [7:0]  i_note_addr,
    input  logic [15:0] i_note_freq,
    input  logic [15:0] i_note_duration,
    input  logic        i_loop_enable,
    input  logic        i_notify_on_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_music_freq,
    output logic        o_music_tone_on,
    output logic        o_music_playing,
    output logic        o_music_done,
    output logic [7:0]  o_music_clip_start,
    output logic [15:0] o_sfx_freq,
    output logic        o_sfx_tone_on,
    output logic        o_sfx_playing,
    output logic        o_sfx_done,
    output logic [7:0]  o_sfx_clip_start
);

    localparam int AW = $clog2(NOTE_DEPTH);

    tcts_pkg::t_item   in_item;
    tcts_pkg::t_item   r_s1;
    tcts_pkg::t_item   r_s2;
    logic              r_s1_v;
    logic              r_s2_v;
    logic              r_s2_done0;
    tcts_pkg::t_chan   r_ch0;
    tcts_pkg::t_chan   r_ch1;
    tcts_pkg::t_step   step0;
    tcts_pkg::t_step   step1;
    tcts_pkg::t_result push_data;
    tcts_pkg::t_result ob_data;
    logic [1:0]        ob_count;
    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    assign in_item.cmd     = i_cmd;
    assign in_item.channel = i_channel;
    assign in_item.addr    = i_note_addr;
    assign in_item.freq    = i_note_freq;
    assign in_item.dur     = i_note_duration;
    assign in_item.loop_en = i_loop_enable;
    assign in_item.notify  = i_notify_on_end;

    // Admit only when stage 1 is free and the buffer has room for everything in flight.
    assign o_in_ready = !r_s1_v && ((ob_count + {1'b0, r_s2_v}) < 2'd2);
    assign accept     = i_in_valid && o_in_ready;

    // Accept cycle reads the music note; stage 1 reads the effects note on a tick, or writes.
    always_comb begin
        ram_we    = r_s1_v && (r_s1.cmd == tcts_pkg::CMD_WRITE);
        ram_re    = accept || (r_s1_v && (r_s1.cmd == tcts_pkg::CMD_TICK));
        ram_waddr = AW'(tcts_pkg::mod_addr(r_s1.addr, NOTE_DEPTH));
        ram_wdata = {r_s1.dur, r_s1.freq};
        if (r_s1_v) begin
            ram_raddr = AW'(tcts_pkg::mod_addr(r_ch1.pos, NOTE_DEPTH));
        end else begin
            ram_raddr = AW'(tcts_pkg::mod_addr(r_ch0.pos, NOTE_DEPTH));
        end
    end

    tcts_ram #(
        .WIDTH (32),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign step0 = tcts_pkg::chan_step(r_ch0, r_s1, 1'b0, ram_rdata);
    assign step1 = tcts_pkg::chan_step(r_ch1, r_s2, 1'b1, ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ch0  <= '0;
            r_ch1  <= '0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            if (r_s1_v) begin
                r_ch0 <= step0.ch;
            end
            if (r_s2_v) begin
                r_ch1 <= step1.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= in_item;
        end
        if (r_s1_v) begin
            r_s2       <= r_s1;
            r_s2_done0 <= step0.done;
        end
    end

    // Music state is already final here; effects state is taken as it updates.
    assign push_data.music = tcts_pkg::chan_view(r_ch0, r_s2_done0);
    assign push_data.sfx   = tcts_pkg::chan_view(step1.ch, step1.done);

    tcts_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_v),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (ob_data),
        .o_count (ob_count)
    );

    assign o_music_freq       = ob_data.music.freq;
    assign o_music_tone_on    = ob_data.music.tone_on;
    assign o_music_playing    = ob_data.music.playing;
    assign o_music_done       = ob_data.music.done;
    assign o_music_clip_start = ob_data.music.clip_start;
    assign o_sfx_freq         = ob_data.sfx.freq;
    assign o_sfx_tone_on      = ob_data.sfx.tone_on;
    assign o_sfx_playing      = ob_data.sfx.playing;
    assign o_sfx_done         = ob_data.sfx.done;
    assign o_sfx_clip_start   = ob_data.sfx.clip_start;

endmodule

// ===== rtl/tcts_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tcts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcts_obuf.sv =====
// Two-entry result buffer between the channel pipeline and the output channel.
// Depends on tcts_pkg for the result type.
module tcts_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcts_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output tcts_pkg::t_result o_data,
    output logic [1:0]        o_count
);

    tcts_pkg::t_result r_buf [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/tcts_checker.sv =====
// Port-level checks for the tone sequencer, bound to the top level.
// Depends on two_channel_tone_sequencer_defines.svh for the assertion macros.
`include "two_channel_tone_sequencer_defines.svh"

module tcts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_music_playing,
    input logic       o_music_done,
    input logic [7:0] o_music_clip_start,
    input logic       o_sfx_playing,
    input logic       o_sfx_done,
    input logic [7:0] o_sfx_clip_start
);

    // A stalled result stays offered.
    `TCTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // An accepted request holds off the input while it sits in stage 1 and uses the note memory port.
    `TCTS_ASSERT_NEXT(a_in_gap, i_in_valid && o_in_ready, !o_in_ready)

    // A done pulse comes only with a channel that has dropped out of play.
    `TCTS_ASSERT_NOW(a_music_done, o_out_valid && o_music_done, !o_music_playing && o_music_clip_start == 8'd0)
    `TCTS_ASSERT_NOW(a_sfx_done, o_out_valid && o_sfx_done, !o_sfx_playing && o_sfx_clip_start == 8'd0)

endmodule

bind two_channel_tone_sequencer tcts_checker u_tcts_checker (.*);
